// File: hw/rtl/pga_pkg.sv
// ----------------------------------------------------------------------------
// pga_pkg: shared types and constants of the page allocator
// Command and status codes, the controller state type, the controller to
// datapath interface structs and the default sizes of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package pga_pkg;

    localparam int NUM_PAGES_DEF  = 32768;
    localparam int PAGE_SHIFT_DEF = 12;
    localparam int COUNT_BITS_DEF = 8;

    localparam int ADDR_W      = 56;
    localparam int FFP_W       = 15;
    localparam int STATUS_W    = 3;
    localparam int CMD_W       = 2;
    localparam int COUNT_OUT_W = 8;
    localparam int CFG_IDX_W   = 1;

    localparam logic [ADDR_W-1:0] BASE_ADDR_RESET = ADDR_W'(64'h8000_0000);

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INC   = 2'd2,
        CMD_GET   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_OOM   = 3'd1,
        ST_BAD   = 3'd2,
        ST_UNDER = 3'd3,
        ST_OVER  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_ADDR  = 1'b0,
        CFG_FIRST_FREE = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_LOOK  = 2'd2,
        S_EXEC  = 2'd3
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic look;
        logic exec;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: hw/rtl/page_allocator_with_refcounts_unit.sv
// ----------------------------------------------------------------------------
// page_allocator_with_refcounts_unit: page allocator with reference counts
// Hands out physical pages from a LIFO free stack or the untouched region and
// keeps one reference count per page; supports alloc, free, increment and get.
//
// Usage:
//   Requests arrive on the in channel (i_cmd, i_page_addr) with valid/ready;
//   one result per request leaves on the out channel with valid/ready.
//   Configuration registers (base address, first free page) are written on
//   the cfg channel, which is always ready; write them only while idle.
//   An accepted transaction runs through the lookup state, which reads the
//   memories and pops the stack, and the execute state, which writes the
//   count, pushes the stack and loads the output register. The next request
//   is accepted in the execute state of the one before it (count RMW).
//   A result waits in the output register while the receiver stalls; the
//   next transaction then runs its lookup and holds in execute until the
//   output register drains.
//   After reset the count memory is swept to zero, one page per cycle, over
//   all NUM_PAGES pages (32768 by default) while o_in_ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module page_allocator_with_refcounts_unit
    import pga_pkg::*;
#(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ADDR_W-1:0]      i_cfg_data,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [CMD_W-1:0]       i_cmd,
    input  wire logic [ADDR_W-1:0]      i_page_addr,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [STATUS_W-1:0]         o_status,
    output logic [ADDR_W-1:0]           o_alloc_addr,
    output logic [COUNT_OUT_W-1:0]      o_count,
    output logic                        o_page_released
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    assign o_cfg_ready = 1'b1;

    pga_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd),
        .i_sts      (dp_sts)
    );

    pga_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_ctl       (dp_cmd),
        .o_sts           (dp_sts),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_page_addr     (i_page_addr),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_alloc_addr    (o_alloc_addr),
        .o_count         (o_count),
        .o_page_released (o_page_released)
    );

endmodule

`default_nettype wire

// File: hw/rtl/pga_ctrl.sv
// ----------------------------------------------------------------------------
// pga_ctrl: sequencing of the page allocator
// Runs the count clearing pass after reset, then steps each transaction
// through the lookup and execute cycles.
// ----------------------------------------------------------------------------
`default_nettype none

module pga_ctrl
    import pga_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    n_state = i_in_valid ? S_LOOK : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.clear  = 1'b0;
        o_cmd.look   = 1'b0;
        o_cmd.exec   = 1'b0;
        case (r_state)
            S_CLEAR: o_cmd.clear = 1'b1;
            S_IDLE:  o_in_ready  = 1'b1;
            S_LOOK:  o_cmd.look  = 1'b1;
            S_EXEC: begin
                // The next transaction is taken in the same cycle the result retires.
                o_cmd.exec = i_sts.out_free;
                o_in_ready = i_sts.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_cmd.accept = o_in_ready & i_in_valid;
    end

endmodule

`default_nettype wire

// File: hw/rtl/pga_dp.sv
// ----------------------------------------------------------------------------
// pga_dp: datapath of the page allocator
// Holds the configuration, the free stack and reference count memories,
// the stack depth and untouched watermark, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pga_dp
    import pga_pkg::*;
#(
    parameter int NUM_PAGES  = NUM_PAGES_DEF,
    parameter int PAGE_SHIFT = PAGE_SHIFT_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_dp_cmd                i_cmd_ctl,
    output t_dp_sts                     o_sts,
    input  wire logic                   i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ADDR_W-1:0]      i_cfg_data,
    input  wire logic [CMD_W-1:0]       i_cmd,
    input  wire logic [ADDR_W-1:0]      i_page_addr,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [STATUS_W-1:0]         o_status,
    output logic [ADDR_W-1:0]           o_alloc_addr,
    output logic [COUNT_OUT_W-1:0]      o_count,
    output logic                        o_page_released
);

    localparam int IW    = $clog2(NUM_PAGES);
    localparam int DW    = $clog2(NUM_PAGES + 1);
    localparam int CW    = (DW > FFP_W) ? DW : FFP_W;
    localparam int DIFFW = ADDR_W + 1;
    localparam logic [DIFFW-1:0]      HI_OFF  = DIFFW'(NUM_PAGES) << PAGE_SHIFT;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    // Configuration.
    logic [ADDR_W-1:0] r_base;
    logic [FFP_W-1:0]  r_ffp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_ADDR_RESET;
            r_ffp  <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BASE_ADDR:  r_base <= i_cfg_data;
                CFG_FIRST_FREE: r_ffp  <= i_cfg_data[FFP_W-1:0];
                default:        r_base <= r_base;
            endcase
        end
    end

    // Accept stage: offset of the address from page zero.
    t_cmd             r_cmd;
    logic [DIFFW-1:0] r_diff;
    logic             r_align;

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.accept) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_diff  <= {1'b0, i_page_addr} - {1'b0, r_base};
            r_align <= (i_page_addr[PAGE_SHIFT-1:0] == '0);
        end
    end

    // Lookup stage: range check, source of an allocated page, memory reads.
    logic [DW-1:0]    r_depth;
    logic [DW-1:0]    r_mark;
    logic             r_ok;
    logic             r_pop;
    logic             r_untouched;
    logic [IW-1:0]    r_idx;

    logic [DIFFW-1:0] lo_off;
    logic             addr_ok;
    logic             is_alloc;
    logic             can_pop;
    logic             can_take;
    logic [IW-1:0]    diff_idx;
    logic [IW-1:0]    stk_raddr;

    always_comb begin
        lo_off    = (r_cmd == CMD_FREE) ? (DIFFW'(r_ffp) << PAGE_SHIFT) : '0;
        addr_ok   = r_align && !r_diff[DIFFW-1] && (r_diff >= lo_off) && (r_diff < HI_OFF);
        is_alloc  = (r_cmd == CMD_ALLOC);
        can_pop   = (r_depth != '0);
        can_take  = !can_pop && (CW'(r_mark) > CW'(r_ffp));
        diff_idx  = r_diff[PAGE_SHIFT +: IW];
        stk_raddr = IW'(r_depth - DW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.look) begin
            r_ok        <= addr_ok;
            r_pop       <= is_alloc && can_pop;
            r_untouched <= is_alloc && can_take;
            r_idx       <= is_alloc ? IW'(r_mark - DW'(1)) : diff_idx;
        end
    end

    // Execute stage.
    logic [COUNT_BITS-1:0] r_cnt_rd;
    logic [IW-1:0]         r_stk_rd;

    logic [STATUS_W-1:0]   n_status;
    logic [ADDR_W-1:0]     n_alloc_addr;
    logic [COUNT_BITS-1:0] n_count;
    logic                  n_rel;
    logic                  exec_cwe;
    logic [IW-1:0]         exec_idx;
    logic [COUNT_BITS-1:0] exec_cdata;
    logic                  push;
    logic                  push_room;

    always_comb begin
        n_status     = ST_OK;
        n_alloc_addr = '0;
        n_count      = '0;
        n_rel        = 1'b0;
        exec_cwe     = 1'b0;
        exec_idx     = r_idx;
        exec_cdata   = '0;
        push         = 1'b0;
        push_room    = (r_depth < DW'(NUM_PAGES));
        case (r_cmd)
            CMD_ALLOC: begin
                exec_idx = r_pop ? r_stk_rd : r_idx;
                if (r_pop || r_untouched) begin
                    exec_cwe     = 1'b1;
                    exec_cdata   = CNT_ONE;
                    n_count      = CNT_ONE;
                    n_alloc_addr = r_base + (ADDR_W'(exec_idx) << PAGE_SHIFT);
                end else begin
                    n_status = ST_OOM;
                end
            end
            CMD_FREE: begin
                if (!r_ok) begin
                    n_status = ST_BAD;
                end else if (r_cnt_rd == '0) begin
                    n_status = ST_UNDER;
                end else begin
                    exec_cwe   = 1'b1;
                    exec_cdata = r_cnt_rd - CNT_ONE;
                    n_count    = exec_cdata;
                    if (exec_cdata == '0) begin
                        n_rel = 1'b1;
                        push  = push_room;
                    end
                end
            end
            CMD_INC: begin
                if (!r_ok) begin
                    n_status = ST_BAD;
                end else if (r_cnt_rd == CNT_MAX) begin
                    n_status = ST_OVER;
                    n_count  = CNT_MAX;
                end else begin
                    exec_cwe   = 1'b1;
                    exec_cdata = r_cnt_rd + CNT_ONE;
                    n_count    = exec_cdata;
                end
            end
            CMD_GET: begin
                if (!r_ok) begin
                    n_status = ST_BAD;
                end else begin
                    n_count = r_cnt_rd;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // Stack depth and untouched watermark.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_mark  <= DW'(NUM_PAGES);
        end else if (i_cmd_ctl.look && is_alloc) begin
            if (can_pop) begin
                r_depth <= r_depth - DW'(1);
            end else if (can_take) begin
                r_mark <= r_mark - DW'(1);
            end
        end else if (i_cmd_ctl.exec && push) begin
            r_depth <= r_depth + DW'(1);
        end
    end

    // Free stack memory.
    logic [IW-1:0] stack_mem [NUM_PAGES];

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.exec && push) begin
            stack_mem[IW'(r_depth)] <= r_idx;
        end
        if (i_cmd_ctl.look) begin
            r_stk_rd <= stack_mem[stk_raddr];
        end
    end

    // Reference count memory, swept to zero after reset.
    logic [IW-1:0]         r_clr;
    logic                  cnt_we;
    logic [IW-1:0]         cnt_waddr;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic [COUNT_BITS-1:0] count_mem [NUM_PAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd_ctl.clear) begin
            r_clr <= r_clr + IW'(1);
        end
    end

    assign o_sts.clear_last = (r_clr == IW'(NUM_PAGES - 1));

    always_comb begin
        cnt_we    = i_cmd_ctl.clear || (i_cmd_ctl.exec && exec_cwe);
        cnt_waddr = i_cmd_ctl.clear ? r_clr : exec_idx;
        cnt_wdata = i_cmd_ctl.clear ? '0 : exec_cdata;
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (i_cmd_ctl.look) begin
            r_cnt_rd <= count_mem[diff_idx];
        end
    end

    // Result register.
    logic                      r_out_valid;
    logic [STATUS_W-1:0]       r_status;
    logic [ADDR_W-1:0]         r_alloc_addr;
    logic [COUNT_BITS-1:0]     r_count;
    logic                      r_rel;
    logic [COUNT_BITS+COUNT_OUT_W-1:0] count_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd_ctl.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.exec) begin
            r_status     <= n_status;
            r_alloc_addr <= n_alloc_addr;
            r_count      <= n_count;
            r_rel        <= n_rel;
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign count_ext       = (COUNT_BITS + COUNT_OUT_W)'(r_count);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_alloc_addr    = r_alloc_addr;
    assign o_count         = count_ext[COUNT_OUT_W-1:0];
    assign o_page_released = r_rel;

endmodule

`default_nettype wire

// File: tb/sv/tb_page_allocator_with_refcounts_unit.sv
// ----------------------------------------------------------------------------
// tb_page_allocator_with_refcounts_unit: self-checking bench of the allocator
// Drives alloc, free, increment and get transactions through the request
// channel. A behavioral copy of the allocator (free stack, untouched region
// and reference counts) predicts every result. Directed tests cover boundary
// addresses, out of memory, release of untouched pages and count saturation.
// Random phases under several register settings follow.
// ----------------------------------------------------------------------------
module tb_page_allocator_with_refcounts_unit;
    import pga_pkg::*;

    localparam int NUM_PAGES  = NUM_PAGES_DEF;
    localparam int PAGE_SHIFT = PAGE_SHIFT_DEF;
    localparam int COUNT_MAX  = (1 << COUNT_BITS_DEF) - 1;
    localparam int QUIET_LIMIT = 150000;
    localparam logic [ADDR_W-1:0] PAGE_BYTES = ADDR_W'(1) << PAGE_SHIFT;
    localparam logic [ADDR_W-1:0] BASE_MAX   = 56'hFF_FFFF_FFFF_0000;

    typedef struct packed {
        t_status                status;
        logic [ADDR_W-1:0]      alloc_addr;
        logic [COUNT_OUT_W-1:0] count;
        logic                   released;
    } t_page_result;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    t_cfg_idx               cfg_index    = CFG_BASE_ADDR;
    logic [ADDR_W-1:0]      cfg_data     = '0;
    logic                   in_valid     = 1'b0;
    logic [CMD_W-1:0]       in_cmd       = CMD_ALLOC;
    logic [ADDR_W-1:0]      in_page_addr = '0;
    logic                   out_ready    = 1'b0;
    logic                   o_cfg_ready;
    logic                   o_in_ready;
    logic                   o_out_valid;
    logic [STATUS_W-1:0]    o_status;
    logic [ADDR_W-1:0]      o_alloc_addr;
    logic [COUNT_OUT_W-1:0] o_count;
    logic                   o_page_released;

    // Behavioral copy of the allocator state and its registers.
    logic [ADDR_W-1:0]      cfg_base = BASE_ADDR_RESET;
    int                     cfg_first_free = 0;
    bit [FFP_W-1:0]         page_stack [NUM_PAGES];
    bit [COUNT_OUT_W-1:0]   page_refs [NUM_PAGES];
    int                     stack_level = 0;
    int                     fresh_mark = NUM_PAGES;

    t_page_result           pending_results [$];
    t_page_result           want;
    int                     held_pages [$];
    int                     error_count = 0;
    int                     stall_left = 0;
    bit                     sender_idles = 1'b1;
    bit                     receiver_idles = 1'b1;

    page_allocator_with_refcounts_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (in_cmd),
        .i_page_addr     (in_page_addr),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_status        (o_status),
        .o_alloc_addr    (o_alloc_addr),
        .o_count         (o_count),
        .o_page_released (o_page_released)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [ADDR_W-1:0] page_address(input int page);
        return cfg_base + (ADDR_W'(page) << PAGE_SHIFT);
    endfunction

    // Range and alignment check; the bounds are kept in 64 bits so that a
    // region reaching past the top of the address space is handled.
    function automatic bit lookup_page(input logic [ADDR_W-1:0] pa, input int low_page,
                                       output int page);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] offset;
        lo = {8'd0, cfg_base} + (64'(low_page) << PAGE_SHIFT);
        hi = {8'd0, cfg_base} + (64'(NUM_PAGES) << PAGE_SHIFT);
        page = 0;
        if (pa[PAGE_SHIFT-1:0] != '0 || {8'd0, pa} < lo || {8'd0, pa} >= hi)
            return 1'b0;
        offset = {8'd0, pa} - {8'd0, cfg_base};
        page = int'(offset >> PAGE_SHIFT);
        return 1'b1;
    endfunction

    task automatic predict_request(input t_cmd cmd, input logic [ADDR_W-1:0] pa,
                                   output int alloc_page);
        t_page_result r;
        int page;
        bit got;
        r.status = ST_OK;
        r.alloc_addr = '0;
        r.count = '0;
        r.released = 1'b0;
        alloc_page = -1;
        page = 0;
        case (cmd)
            CMD_ALLOC: begin
                got = 1'b1;
                if (stack_level > 0) begin
                    stack_level--;
                    page = int'(page_stack[stack_level]);
                end else if (fresh_mark > cfg_first_free) begin
                    fresh_mark--;
                    page = fresh_mark;
                end else begin
                    got = 1'b0;
                    r.status = ST_OOM;
                end
                if (got) begin
                    page_refs[page] = COUNT_OUT_W'(1);
                    r.count = COUNT_OUT_W'(1);
                    r.alloc_addr = page_address(page);
                    alloc_page = page;
                end
            end
            CMD_FREE: begin
                if (!lookup_page(pa, cfg_first_free, page)) begin
                    r.status = ST_BAD;
                end else if (page_refs[page] == '0) begin
                    r.status = ST_UNDER;
                end else begin
                    page_refs[page]--;
                    r.count = page_refs[page];
                    if (page_refs[page] == '0) begin
                        r.released = 1'b1;
                        // A push onto a full stack is lost, the release still shows.
                        if (stack_level < NUM_PAGES) begin
                            page_stack[stack_level] = FFP_W'(page);
                            stack_level++;
                        end
                    end
                end
            end
            default: begin
                if (!lookup_page(pa, 0, page)) begin
                    r.status = ST_BAD;
                end else if (cmd == CMD_INC) begin
                    if (page_refs[page] == COUNT_OUT_W'(COUNT_MAX)) begin
                        r.status = ST_OVER;
                        r.count = COUNT_OUT_W'(COUNT_MAX);
                    end else begin
                        page_refs[page]++;
                        r.count = page_refs[page];
                    end
                end else begin
                    r.count = page_refs[page];
                end
            end
        endcase
        pending_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (error_count < 50)
            $display("mismatch on %s: got 0x%0h, expected 0x%0h", what, got, exp_val);
        error_count++;
    endtask

    task automatic send_request(input t_cmd cmd, input logic [ADDR_W-1:0] pa);
        int alloc_page;
        if (sender_idles && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_cmd       <= cmd;
        in_page_addr <= pa;
        do @(posedge clk); while (!o_in_ready);
        predict_request(cmd, pa, alloc_page);
        if (alloc_page >= 0)
            held_pages.push_back(alloc_page);
    endtask

    // Holds the request channel until every pending result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input t_cfg_idx idx, input logic [ADDR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!o_cfg_ready);
        if (idx == CFG_BASE_ADDR)
            cfg_base = data;
        else
            cfg_first_free = int'(data[FFP_W-1:0]);
    endtask

    task automatic apply_settings(input logic [ADDR_W-1:0] base, input int first_free);
        settle();
        write_register(CFG_BASE_ADDR, base);
        write_register(CFG_FIRST_FREE, ADDR_W'(first_free));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_request();
        int roll;
        int pos;
        int page;
        t_cmd cmd;
        logic [ADDR_W-1:0] pa;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            cmd = t_cmd'($urandom_range(0, 3));
            case ($urandom_range(0, 4))
                0: pa = ADDR_W'({$urandom(), $urandom()});
                1: pa = page_address($urandom_range(0, NUM_PAGES - 1))
                        | ADDR_W'($urandom_range(1, 4095));
                2: pa = cfg_base - PAGE_BYTES * ADDR_W'($urandom_range(1, 3));
                3: pa = page_address(NUM_PAGES + $urandom_range(0, 2));
                default: pa = page_address($urandom_range(0, NUM_PAGES - 1));
            endcase
            send_request(cmd, pa);
        end else if (held_pages.size() == 0 || (roll < 35 && held_pages.size() < 24)) begin
            send_request(CMD_ALLOC, ADDR_W'({$urandom(), $urandom()}));
        end else begin
            pos = $urandom_range(0, held_pages.size() - 1);
            page = held_pages[pos];
            if (page < cfg_first_free) begin
                // Below the free boundary the page can never be returned.
                held_pages.delete(pos);
                send_request(CMD_ALLOC, ADDR_W'({$urandom(), $urandom()}));
            end else begin
                roll = $urandom_range(0, 99);
                cmd = (roll < 45) ? CMD_FREE : (roll < 70) ? CMD_INC : CMD_GET;
                send_request(cmd, page_address(page));
                if (page_refs[page] == '0)
                    held_pages.delete(pos);
            end
        end
    endtask

    task automatic run_traffic_phase(input int n, input logic [ADDR_W-1:0] base,
                                     input int first_free, input bit s_idle, input bit r_idle);
        apply_settings(base, first_free);
        sender_idles = s_idle;
        receiver_idles = r_idle;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 199) == 0)
                settle();
            random_request();
        end
    endtask

    task automatic test_reset_defaults();
        send_request(CMD_ALLOC, '0);
        send_request(CMD_GET, page_address(NUM_PAGES - 1));
        send_request(CMD_INC, page_address(NUM_PAGES - 1));
        send_request(CMD_FREE, page_address(NUM_PAGES - 1));
        send_request(CMD_FREE, page_address(NUM_PAGES - 1));
        send_request(CMD_FREE, page_address(NUM_PAGES - 1));
        send_request(CMD_GET, page_address(0));
        send_request(CMD_INC, cfg_base - PAGE_BYTES);
        send_request(CMD_GET, page_address(NUM_PAGES));
        send_request(CMD_FREE, page_address(NUM_PAGES - 1) + ADDR_W'(1));
        send_request(CMD_GET, '1);
        send_request(CMD_ALLOC, '1);
    endtask

    // With the free boundary at the last page, nothing is left to hand out.
    task automatic test_out_of_memory();
        apply_settings('0, NUM_PAGES - 1);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_FREE, page_address(NUM_PAGES - 1));
        send_request(CMD_FREE, page_address(0));
        send_request(CMD_INC, page_address(0));
        send_request(CMD_ALLOC, '0);
        send_request(CMD_ALLOC, '0);
    endtask

    // Only the first sixteen pages are addressable at the highest base.
    task automatic test_untouched_page_free();
        apply_settings(BASE_MAX, 4);
        send_request(CMD_INC, page_address(10));
        send_request(CMD_FREE, page_address(10));
        send_request(CMD_FREE, page_address(2));
        send_request(CMD_GET, page_address(15));
        send_request(CMD_GET, '1);
        send_request(CMD_ALLOC, '0);
        send_request(CMD_ALLOC, '0);
    endtask

    task automatic test_count_saturation();
        int page;
        apply_settings(BASE_ADDR_RESET, 0);
        send_request(CMD_ALLOC, '0);
        page = held_pages[$];
        repeat (COUNT_MAX) send_request(CMD_INC, page_address(page));
        send_request(CMD_GET, page_address(page));
        send_request(CMD_FREE, page_address(page));
    endtask

    task automatic test_random_default();
        run_traffic_phase(400, BASE_ADDR_RESET, 0, 1'b1, 1'b1);
    endtask

    task automatic test_random_settings();
        logic [ADDR_W-1:0] base;
        base = {1'b0, 11'($urandom()), 32'($urandom()), 12'd0};
        run_traffic_phase(250, base, $urandom_range(0, fresh_mark), 1'b1, 1'b0);
    endtask

    // A free boundary just under the untouched mark drains memory quickly.
    task automatic test_exhaustion();
        run_traffic_phase(200, '0, (fresh_mark > 6) ? fresh_mark - 6 : 0, 1'b0, 1'b1);
    endtask

    task automatic test_random_zero_base();
        run_traffic_phase(250, '0, 0, 1'b1, 1'b1);
    endtask

    task automatic test_random_full_rate();
        logic [ADDR_W-1:0] base;
        base = {1'b0, 11'($urandom()), 32'($urandom()), 12'd0};
        run_traffic_phase(250, base, 0, 1'b0, 1'b0);
    endtask

    // Result checking and receiver stalls.
    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("status of a result with nothing pending", 64'(o_status),
                                64'd0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
                if (o_alloc_addr !== want.alloc_addr)
                    report_mismatch("alloc_addr", 64'(o_alloc_addr), 64'(want.alloc_addr));
                if (o_count !== want.count)
                    report_mismatch("count", 64'(o_count), 64'(want.count));
                if (o_page_released !== want.released)
                    report_mismatch("page_released", 64'(o_page_released),
                                    64'(want.released));
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // The clearing sweep after reset is the longest stretch without a transaction.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)
                    || (cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_out_of_memory();
        test_untouched_page_free();
        test_count_saturation();
        test_random_default();
        test_random_settings();
        test_exhaustion();
        test_random_zero_base();
        test_random_full_rate();
        settle();
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
